@@ design/afbd_pkg.sv @@
// ---------------------------------------------------------------------------
// afbd_pkg: shared types, constants and sigmoid table for the box decoder
// Holds the config register codes, queue item format, box scaling helper and
// the sigmoid lookup table, which is built at elaboration.
// ---------------------------------------------------------------------------
`default_nettype none

package afbd_pkg;

  // Number of stride levels (strides 8, 16, 32).
  localparam int NUM_LEVELS = 3;
  localparam int LEVEL_W    = 2;

  // Sigmoid table geometry. The table spans Q8.8 logits [-16, 16).
  localparam int SIGMOID_TABLE_BITS = 10;
  localparam int ROM_SIZE           = 1 << SIGMOID_TABLE_BITS;
  localparam int ROM_SHIFT          = 13 - SIGMOID_TABLE_BITS;
  localparam int ROM_STEP           = 1 << ROM_SHIFT;
  localparam int ROM_HALF           = ROM_STEP / 2;

  localparam logic [63:0] EXP_NEG_ONE_Q32 = 64'd1580030169;

  // Field widths.
  localparam int VALUE_W = 16;
  localparam int COUNT_W = 8;
  localparam int IMAGE_W = 11;
  localparam int PROB_W  = 16;
  localparam int POS_W   = 9;

  // Config port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THR   = 2'd2;

  localparam logic [COUNT_W-1:0] CLASS_COUNT_RST = 8'd1;
  localparam logic [IMAGE_W-1:0] IMAGE_SIZE_RST  = 11'd640;
  localparam logic [PROB_W-1:0]  SCORE_THR_RST   = 16'd26214;

  // Front-to-back queue.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_LEFT,
    KIND_TOP,
    KIND_RIGHT,
    KIND_BOTTOM,
    KIND_CLASS
  } kind_e;

  typedef struct packed {
    kind_e                      kind;
    logic signed [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]         label;
    logic [7:0]                 col;
    logic [7:0]                 row;
    logic [LEVEL_W-1:0]         level;
  } item_t;

  // Queue write side and read side.
  typedef struct packed {
    logic  valid;
    item_t item;
  } qword_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] width;
    logic signed [15:0] height;
  } box_t;

  // floor(x * 2^(level+3) / 16), saturated to 16 bits signed.
  function automatic logic signed [15:0] scale_sat(input logic signed [17:0] x,
                                                   input logic [LEVEL_W-1:0] level);
    logic signed [21:0] w;
    w = 22'(x) <<< level;
    w = w >>> 1;
    if (w > 22'sd32767) begin
      return 16'sh7fff;
    end else if (w < -22'sd32768) begin
      return 16'sh8000;
    end
    return w[15:0];
  endfunction

  // Unsigned long division by shift and subtract (elaboration only).
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^(-t), t in Q16, result in Q0.32.
  function automatic logic [63:0] exp_neg_q32(input logic [63:0] t);
    logic [63:0]        n;
    logic [63:0]        f;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [65:0] sum;
    n    = t >> 16;
    f    = t & 64'hffff;
    sum  = 66'sd1 <<< 32;
    term = 64'd1 << 32;
    for (int k = 1; k <= 12; k++) begin
      term = udiv64((term * f) >> 16, 64'(k));
      if ((k & 1) != 0) begin
        sum = sum - $signed({2'b00, term});
      end else begin
        sum = sum + $signed({2'b00, term});
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    v = sum[63:0];
    for (int i = 0; i < 32; i++) begin
      if (n != 0 && v != 0) begin
        v = (v * EXP_NEG_ONE_Q32) >> 32;
        n = n - 64'd1;
      end
    end
    return v;
  endfunction

  function automatic logic [15:0] sigmoid_q16(input int xq8);
    logic [63:0] a;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] p;
    a = 64'(xq8 < 0 ? -xq8 : xq8) << 8;
    e = exp_neg_q32(a);
    d = (64'd1 << 32) + e;
    if (xq8 >= 0) begin
      p = udiv64((64'd1 << 48) + (d >> 1), d);
    end else begin
      p = udiv64((e << 16) + (d >> 1), d);
    end
    if (p > 64'd65535) begin
      p = 64'd65535;
    end
    return p[15:0];
  endfunction

  typedef logic [PROB_W-1:0] sig_rom_t [ROM_SIZE];

  function automatic sig_rom_t build_rom();
    sig_rom_t r;
    for (int i = 0; i < ROM_SIZE; i++) begin
      r[i] = sigmoid_q16(-4096 + i * ROM_STEP + ROM_HALF);
    end
    return r;
  endfunction

  localparam sig_rom_t SIG_ROM = build_rom();

endpackage

`default_nettype wire

@@ design/afbd_in_if.sv @@
// ---------------------------------------------------------------------------
// afbd_in_if: head element stream channel
// Valid/ready channel carrying one Q8.8 head element and a frame start flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface afbd_in_if
  import afbd_pkg::*;
  ;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] head_value;
  logic                      frame_start;

  modport source (output valid, head_value, frame_start, input ready);
  modport sink   (input valid, head_value, frame_start, output ready);
endinterface

`default_nettype wire

@@ design/afbd_out_if.sv @@
// ---------------------------------------------------------------------------
// afbd_out_if: detection stream channel
// Valid/ready channel carrying one decoded detection word.
// ---------------------------------------------------------------------------
`default_nettype none

interface afbd_out_if
  import afbd_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic signed [15:0] box_left;
  logic signed [15:0] box_top;
  logic signed [15:0] box_width;
  logic signed [15:0] box_height;
  logic [COUNT_W-1:0] class_label;
  logic [PROB_W-1:0]  class_prob;

  modport source (output valid, box_left, box_top, box_width, box_height,
                  class_label, class_prob, input ready);
  modport sink   (input valid, box_left, box_top, box_width, box_height,
                  class_label, class_prob, output ready);
endinterface

`default_nettype wire

@@ design/anchor_free_box_decode.sv @@
// ---------------------------------------------------------------------------
// anchor_free_box_decode: streaming decoder for an anchor-free detector head
//
// in_i carries one signed Q8.8 head element per word, row-major; each row is
// left, top, right, bottom, objectness (ignored), then class_count logits.
// frame_start on a word clears the row and anchor counters before it is used.
// Anchors come from internal counters: (col + 0.5, row + 0.5) * stride over
// strides 8, 16, 32, grid side image_size >> (3 + level).
// out_o carries one detection word (Q12.4 box, class label, Q0.16 prob) for
// each class logit whose sigmoid is strictly above the score threshold.
// Config: cfg_we_i writes cfg_data_i into register cfg_index_i (0 class_count,
// 1 image_size, 2 score threshold); write only while the block is idle.
// Throughput: one word per cycle on both sides while out_o is ready. Each
// detection passes through the queue, then the registered sigmoid table read,
// then the output register, on its way to out_o.
// Reset: counters, held box and pipeline clear; config returns to 1/640/26214.
// Stall: out_o holds its word while ready is low; the back end stops, the
// four-entry queue between front and back fills, and then in_i.ready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module anchor_free_box_decode
  import afbd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  afbd_in_if.sink                    in_i,
  afbd_out_if.source                 out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration registers
  logic [COUNT_W-1:0] class_count_q;
  logic [IMAGE_W-1:0] image_size_q;
  logic [PROB_W-1:0]  threshold_q;

  // front -> queue -> back
  qword_t push;
  qword_t head;
  logic   full;
  logic   pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q <= CLASS_COUNT_RST;
      image_size_q  <= IMAGE_SIZE_RST;
      threshold_q   <= SCORE_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CLASS_COUNT: class_count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_IMAGE_SIZE:  image_size_q  <= cfg_data_i[IMAGE_W-1:0];
        CFG_SCORE_THR:   threshold_q   <= cfg_data_i[PROB_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // Front: counts slots and anchors, tags each element.
  afbd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .class_count_i (class_count_q),
    .image_size_i  (image_size_q),
    .full_i        (full),
    .push_o        (push)
  );

  // Queue decouples the counters from the output stall.
  afbd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  // Back: box math, sigmoid lookup, threshold, output register.
  afbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .threshold_i (threshold_q),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

@@ design/afbd_front.sv @@
// ---------------------------------------------------------------------------
// afbd_front: row and anchor counters
// Accepts head elements, tags each with its slot kind and anchor position,
// and pushes the useful ones into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module afbd_front
  import afbd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  afbd_in_if.sink                 in_i,
  input  wire logic [COUNT_W-1:0] class_count_i,
  input  wire logic [IMAGE_W-1:0] image_size_i,
  input  wire logic               full_i,
  output qword_t                  push_o
);

  logic [POS_W-1:0]   pos_q, pos_d, pos_e;
  logic [7:0]         col_q, col_d, col_e;
  logic [7:0]         row_q, row_d, row_e;
  logic [LEVEL_W-1:0] lvl_q, lvl_d, lvl_e;
  logic               accept;
  logic [POS_W-1:0]   last;
  logic [IMAGE_W-1:0] dim_sh;
  logic [7:0]         dim;
  logic [7:0]         col_inc, row_inc;
  logic [LEVEL_W:0]   lvl_inc;
  kind_e              kind;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  // frame start clears the counters before this element is used
  assign pos_e = in_i.frame_start ? '0 : pos_q;
  assign col_e = in_i.frame_start ? '0 : col_q;
  assign row_e = in_i.frame_start ? '0 : row_q;
  assign lvl_e = in_i.frame_start ? '0 : lvl_q;

  assign last   = POS_W'(4) + POS_W'(class_count_i);
  assign dim_sh = image_size_i >> (4'd3 + 4'(lvl_e));
  assign dim    = (dim_sh[7:0] == 8'd0) ? 8'd1 : dim_sh[7:0];

  assign col_inc = col_e + 8'd1;
  assign row_inc = row_e + 8'd1;
  assign lvl_inc = {1'b0, lvl_e} + (LEVEL_W+1)'(1);

  always_comb begin
    case (pos_e)
      POS_W'(0): kind = KIND_LEFT;
      POS_W'(1): kind = KIND_TOP;
      POS_W'(2): kind = KIND_RIGHT;
      POS_W'(3): kind = KIND_BOTTOM;
      default:   kind = KIND_CLASS;
    endcase
  end

  always_comb begin
    push_o.valid      = accept && (pos_e != POS_W'(4));
    push_o.item.kind  = kind;
    push_o.item.value = in_i.head_value;
    push_o.item.label = COUNT_W'(pos_e - POS_W'(5));
    push_o.item.col   = col_e;
    push_o.item.row   = row_e;
    push_o.item.level = lvl_e;
  end

  always_comb begin
    pos_d = pos_q;
    col_d = col_q;
    row_d = row_q;
    lvl_d = lvl_q;
    if (accept) begin
      col_d = col_e;
      row_d = row_e;
      lvl_d = lvl_e;
      if (pos_e >= last) begin
        pos_d = '0;
        col_d = col_inc;
        if (col_inc >= dim) begin
          col_d = '0;
          row_d = row_inc;
          if (row_inc >= dim) begin
            row_d = '0;
            lvl_d = (int'(lvl_inc) >= NUM_LEVELS) ? '0 : lvl_inc[LEVEL_W-1:0];
          end
        end
      end else begin
        pos_d = pos_e + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      col_q <= '0;
      row_q <= '0;
      lvl_q <= '0;
    end else begin
      pos_q <= pos_d;
      col_q <= col_d;
      row_q <= row_d;
      lvl_q <= lvl_d;
    end
  end

  a_level_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(lvl_q) < NUM_LEVELS)
    else $error("stride level out of range");

endmodule

`default_nettype wire

@@ design/afbd_queue.sv @@
// ---------------------------------------------------------------------------
// afbd_queue: short item queue between front and back
// Register FIFO; full drops the input ready, empty idles the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module afbd_queue
  import afbd_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire qword_t push_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output qword_t      head_o
);

  item_t                  mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic                   do_push, do_pop;

  assign full_o       = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QUEUE_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= QUEUE_PTR_W'((int'(wr_ptr_q) + 1) % QUEUE_DEPTH);
      end
      if (do_pop) begin
        rd_ptr_q <= QUEUE_PTR_W'((int'(rd_ptr_q) + 1) % QUEUE_DEPTH);
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> !full_o)
    else $error("push into full queue");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ design/afbd_back.sv @@
// ---------------------------------------------------------------------------
// afbd_back: box former, sigmoid lookup and threshold
// Pops queued items, forms the Q12.4 box on the bottom offset, looks up the
// sigmoid for class logits and registers detections above threshold.
// ---------------------------------------------------------------------------
`default_nettype none

module afbd_back
  import afbd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire qword_t            head_i,
  output logic                   pop_o,
  input  wire logic [PROB_W-1:0] threshold_i,
  afbd_out_if.source             out_o
);

  // held offsets, then the finished box
  box_t                     held_q, held_d;
  // lookup stage
  logic                     s1_valid_q, s1_valid_d;
  box_t                     s1_box_q;
  logic [COUNT_W-1:0]       s1_label_q;
  logic [PROB_W-1:0]        rom_q;
  // output register
  logic                     out_valid_q, out_valid_d;
  box_t                     out_box_q;
  logic [COUNT_W-1:0]       out_label_q;
  logic [PROB_W-1:0]        out_prob_q;

  logic                     out_free, s1_free, load_class, load_out;
  item_t                    it;
  logic signed [17:0]       ax, ay, lw, tw, rw, bw;
  logic signed [16:0]       logit_u;
  logic [16:0]              idx_w;
  logic [SIGMOID_TABLE_BITS-1:0] rom_idx;

  assign it       = head_i.item;
  assign out_free = !out_valid_q || out_o.ready;
  assign s1_free  = !s1_valid_q || out_free;
  assign pop_o    = head_i.valid && s1_free;
  assign load_class = pop_o && (it.kind == KIND_CLASS);
  assign load_out   = s1_valid_q && out_free;

  // anchor center in Q8.8: cell index plus one half
  assign ax = $signed({2'b00, it.col, 8'h80});
  assign ay = $signed({2'b00, it.row, 8'h80});
  assign lw = 18'(held_q.left);
  assign tw = 18'(held_q.top);
  assign rw = 18'(held_q.width);
  assign bw = 18'(it.value);

  always_comb begin
    held_d = held_q;
    if (pop_o) begin
      case (it.kind)
        KIND_LEFT:   held_d.left  = it.value;
        KIND_TOP:    held_d.top   = it.value;
        KIND_RIGHT:  held_d.width = it.value;
        KIND_BOTTOM: begin
          held_d.left   = scale_sat(ax - lw, it.level);
          held_d.top    = scale_sat(ay - tw, it.level);
          held_d.width  = scale_sat(lw + rw, it.level);
          held_d.height = scale_sat(tw + bw, it.level);
        end
        default: held_d = held_q;
      endcase
    end
  end

  // table index, clamped at both ends
  assign logit_u = 17'(it.value) + 17'sd4096;
  assign idx_w   = 17'(logit_u) >> ROM_SHIFT;
  always_comb begin
    if (logit_u < 0) begin
      rom_idx = '0;
    end else if (idx_w > 17'(ROM_SIZE - 1)) begin
      rom_idx = SIGMOID_TABLE_BITS'(ROM_SIZE - 1);
    end else begin
      rom_idx = idx_w[SIGMOID_TABLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_class) begin
      rom_q      <= SIG_ROM[rom_idx];
      s1_box_q   <= held_q;
      s1_label_q <= it.label;
    end
    if (load_out) begin
      out_box_q   <= s1_box_q;
      out_label_q <= s1_label_q;
      out_prob_q  <= rom_q;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_free) begin
      s1_valid_d = load_class;
    end
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = (rom_q > threshold_i);
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      held_q      <= held_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.box_left    = out_box_q.left;
  assign out_o.box_top     = out_box_q.top;
  assign out_o.box_width   = out_box_q.width;
  assign out_o.box_height  = out_box_q.height;
  assign out_o.class_label = out_label_q;
  assign out_o.class_prob  = out_prob_q;

  a_class_enters_lookup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_class |=> s1_valid_q)
    else $error("class logit lost before lookup stage");

endmodule

`default_nettype wire

@@ tb/tb_anchor_free_box_decode.sv @@
// ---------------------------------------------------------------------------
// tb_anchor_free_box_decode: self-checking bench for the box decoder
// Streams head words through the decoder under several register settings,
// predicts every detection with an independent model of the anchor counters,
// box math and sigmoid table, and checks each detection word in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_anchor_free_box_decode;
  import afbd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_N       = 1 << SIGMOID_TABLE_BITS;
  localparam int TBL_SHIFT   = 13 - SIGMOID_TABLE_BITS;
  localparam int TBL_STEP    = 1 << TBL_SHIFT;
  localparam int SETTLE      = 16;       // queue depth plus pipeline, with margin
  localparam int CYCLE_LIMIT = 400000;   // far above the slowest legal run
  localparam longint unsigned E_MINUS_ONE_Q32 = 64'd1580030169;

  // One head word as the sender sees it.
  typedef struct packed {
    logic signed [15:0] value;
    logic               start;
  } head_word_t;

  // One detection word.
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] width;
    logic signed [15:0] height;
    logic [7:0]         label;
    logic [15:0]        prob;
  } det_t;

  // -------------------------------------------------------------------------
  // Detection predictor and checker. Mirrors the decoder's counters, held box
  // and registers, and keeps the detections still owed by the block.
  // -------------------------------------------------------------------------
  class box_decode_board;
    det_t               owed[$];
    int                 errors;
    int                 shown;
    logic [15:0]        sig_tbl[TBL_N];
    int                 cls_count;
    int                 img_side;
    int                 thr;
    int                 row_pos;
    logic [7:0]         col;
    logic [7:0]         row;
    logic [1:0]         lvl;
    logic signed [15:0] h_left;
    logic signed [15:0] h_top;
    logic signed [15:0] h_width;
    logic signed [15:0] h_height;

    function new();
      int i;
      for (i = 0; i < TBL_N; i++) begin
        sig_tbl[i] = logistic_q16(-4096 + i * TBL_STEP + TBL_STEP / 2);
      end
      errors    = 0;
      shown     = 0;
      cls_count = 1;
      img_side  = 640;
      thr       = 26214;
      clear_counters();
      h_left    = '0;
      h_top     = '0;
      h_width   = '0;
      h_height  = '0;
    endfunction

    // e^(-t), t in Q16, result in Q0.32: series on the fraction, then e^-1 per unit
    function longint unsigned neg_exp_q32(longint unsigned t);
      longint unsigned whole;
      longint unsigned frac;
      longint unsigned term;
      longint unsigned v;
      longint          acc;
      int              k;
      whole = t >> 16;
      frac  = t & 64'hFFFF;
      acc   = 64'sd1 <<< 32;
      term  = 64'd1 << 32;
      for (k = 1; k <= 12; k++) begin
        term = ((term * frac) >> 16) / longint'(k);
        if (k % 2 == 1) acc = acc - longint'(term);
        else            acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      v = longint'(acc);
      while (whole > 0 && v != 0) begin
        v = (v * E_MINUS_ONE_Q32) >> 32;
        whole--;
      end
      return v;
    endfunction

    function logic [15:0] logistic_q16(int x);
      longint unsigned mag;
      longint unsigned e;
      longint unsigned d;
      longint unsigned p;
      mag = (x < 0) ? longint'(-x) : longint'(x);
      mag = mag << 8;
      e   = neg_exp_q32(mag);
      d   = (64'd1 << 32) + e;
      if (x >= 0) p = ((64'd1 << 48) + d / 2) / d;
      else        p = ((e << 16) + d / 2) / d;
      if (p > 65535) p = 65535;
      return 16'(p);
    endfunction

    function logic [15:0] prob_of(int logit);
      int u;
      int idx;
      u = logit + 4096;
      if (u < 0) return sig_tbl[0];
      idx = u >>> TBL_SHIFT;
      if (idx > TBL_N - 1) idx = TBL_N - 1;
      return sig_tbl[idx];
    endfunction

    function logic signed [15:0] sat16(longint x);
      if (x > 32767)  return 16'sh7FFF;
      if (x < -32768) return 16'sh8000;
      return 16'(x);
    endfunction

    function void clear_counters();
      row_pos = 0;
      col     = '0;
      row     = '0;
      lvl     = '0;
    endfunction

    // Cells per side at the current level; an empty grid counts as one cell.
    function int cells();
      int d;
      d = img_side >> (3 + lvl);
      return (d == 0) ? 1 : d;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CLASS_COUNT: cls_count = int'(data[7:0]);
        CFG_IMAGE_SIZE:  img_side  = int'(data[10:0]);
        CFG_SCORE_THR:   thr       = int'(data);
        default: ;
      endcase
    endfunction

    function void note_word(head_word_t w);
      longint stride;
      longint ax;
      longint ay;
      longint l;
      longint t;
      longint r;
      longint b;
      int     dim;
      det_t   d;
      logic [15:0] p;
      if (w.start) clear_counters();
      case (row_pos)
        0: h_left  = w.value;
        1: h_top   = w.value;
        2: h_width = w.value;
        3: begin
          stride   = 64'sd8 <<< lvl;
          ax       = longint'(col) * 256 + 128;
          ay       = longint'(row) * 256 + 128;
          l        = h_left;
          t        = h_top;
          r        = h_width;
          b        = w.value;
          h_left   = sat16(((ax - l) * stride) >>> 4);
          h_top    = sat16(((ay - t) * stride) >>> 4);
          h_width  = sat16(((l + r) * stride) >>> 4);
          h_height = sat16(((t + b) * stride) >>> 4);
        end
        4: ;  // objectness, not used
        default: begin
          p = prob_of(int'(w.value));
          if (int'(p) > thr) begin
            d = {h_left, h_top, h_width, h_height, 8'(row_pos - 5), p};
            owed.insert(owed.size(), d);
          end
        end
      endcase
      if (row_pos >= 4 + cls_count) begin
        row_pos = 0;
        dim = cells();
        col = col + 8'd1;
        if (int'(col) >= dim) begin
          col = '0;
          row = row + 8'd1;
          if (int'(row) >= dim) begin
            row = '0;
            lvl = (int'(lvl) + 1 >= NUM_LEVELS) ? 2'd0 : lvl + 2'd1;
          end
        end
      end else begin
        row_pos++;
      end
    endfunction

    function void check_det(det_t got);
      det_t want;
      if (owed.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected detection: box (%0d,%0d,%0d,%0d) class %0d prob %0d",
                   got.left, got.top, got.width, got.height, got.label, got.prob);
        end
        return;
      end
      want = owed.pop_front();
      if (got.left !== want.left || got.top !== want.top || got.width !== want.width ||
          got.height !== want.height || got.label !== want.label ||
          got.prob !== want.prob) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: expected box (%0d,%0d,%0d,%0d) class %0d prob %0d",
                   want.left, want.top, want.width, want.height, want.label, want.prob);
          $display("          actual   box (%0d,%0d,%0d,%0d) class %0d prob %0d",
                   got.left, got.top, got.width, got.height, got.label, got.prob);
        end
      end
    endfunction

    function void flag_leftover();
      if (owed.size() != 0) begin
        errors += owed.size();
        if (shown < 10) begin
          shown++;
          $display("%0d expected detections never arrived", owed.size());
        end
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset, channels and the block itself.
  // -------------------------------------------------------------------------
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  afbd_in_if  in_if ();
  afbd_out_if out_if ();

  anchor_free_box_decode dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  box_decode_board board;
  head_word_t      word_q[$];   // words waiting to be sent
  int              cur_cls;     // class count as last written, for row shaping
  bit              calm;        // when set neither side idles
  int              cycle_cnt;

  initial begin
    in_if.valid       = 1'b0;
    in_if.head_value  = '0;
    in_if.frame_start = 1'b0;
    out_if.ready      = 1'b0;
    calm              = 1'b0;
    cur_cls           = 1;
    cycle_cnt         = 0;
  end

  // Receiver: ready changes at the falling edge, idling about 16% of cycles.
  initial begin
    forever begin
      @(negedge clk_i);
      out_if.ready <= calm || ($urandom_range(99) >= 16);
    end
  end

  // Every detection word taken at a rising edge is checked at once.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      board.check_det({out_if.box_left, out_if.box_top, out_if.box_width,
                       out_if.box_height, out_if.class_label, out_if.class_prob});
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers.
  // -------------------------------------------------------------------------

  // Box offsets: mostly within a few cells, sometimes anything, for saturation.
  function automatic logic signed [15:0] pick_offset();
    if ($urandom_range(99) < 80) return 16'($signed($urandom_range(4095)) - 2048);
    return 16'($urandom_range(65535));
  endfunction

  // Logits: dense around the threshold, across the table, and far outside it.
  function automatic logic signed [15:0] pick_logit();
    int sel;
    sel = $urandom_range(3);
    if (sel < 2)  return 16'($signed($urandom_range(2400)) - 1200);
    if (sel == 2) return 16'($signed($urandom_range(8600)) - 4300);
    return 16'($urandom_range(65535));
  endfunction

  // Queue up rows of 5 + class count words. frame_rows bounds the rows in a
  // frame; zero means one long frame started once. A noisy phase breaks a few
  // rows: cut short and/or with a stray frame start inside.
  task automatic make_words(int n_words, int frame_rows, bit noisy);
    int         row_len;
    int         left_in_frame;
    int         cut;
    int         stray;
    int         j;
    bit         first;
    head_word_t w;
    first         = 1'b1;
    left_in_frame = 0;
    while (word_q.size() < n_words) begin
      row_len = 5 + cur_cls;
      cut     = row_len;
      stray   = -1;
      if (noisy && $urandom_range(99) < 8) begin
        cut   = $urandom_range(row_len, 1);
        stray = $urandom_range(cut - 1);
      end
      for (j = 0; j < cut; j++) begin
        w.value = (j < 4) ? pick_offset() : (j == 4) ? 16'($urandom_range(65535))
                                                     : pick_logit();
        w.start = (j == stray);
        if (j == 0) begin
          if (frame_rows == 0) begin
            w.start = w.start | first;
          end else if (left_in_frame == 0) begin
            w.start       = 1'b1;
            left_in_frame = $urandom_range(frame_rows, 1);
          end
        end
        word_q.insert(word_q.size(), w);
      end
      first = 1'b0;
      if (left_in_frame > 0) left_in_frame--;
    end
  endtask

  // Sender: words change at the falling edge; a word stays up until taken.
  task automatic send_words();
    head_word_t w;
    while (word_q.size() != 0) begin
      @(negedge clk_i);
      if (!calm && $urandom_range(99) < 16) begin
        in_if.valid <= 1'b0;
      end else begin
        w = word_q.pop_front();
        in_if.valid       <= 1'b1;
        in_if.head_value  <= w.value;
        in_if.frame_start <= w.start;
        @(posedge clk_i);
        while (!in_if.ready) @(posedge clk_i);
        board.note_word(w);
      end
    end
    @(negedge clk_i);
    in_if.valid <= 1'b0;
  endtask

  // Wait for every owed detection, then let words that emit nothing clear
  // the queue and pipeline.
  task automatic drain(bit settle);
    while (board.owed.size() != 0) @(posedge clk_i);
    if (settle) repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write all three registers on consecutive cycles; the block is idle here.
  task automatic set_regs(int cls, int img, int thr);
    logic [CFG_IDX_W-1:0]  idx[3];
    logic [CFG_DATA_W-1:0] val[3];
    int                    k;
    idx = '{CFG_CLASS_COUNT, CFG_IMAGE_SIZE, CFG_SCORE_THR};
    val = '{16'(cls), 16'(img), 16'(thr)};
    for (k = 0; k < 3; k++) begin
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      @(posedge clk_i);
      board.write_reg(idx[k], val[k]);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_cls = cls & 8'hFF;
  endtask

  task automatic run_phase(int cls, int img, int thr, int n_words, int frame_rows,
                           bit noisy);
    set_regs(cls, img, thr);
    make_words(n_words, frame_rows, noisy);
    send_words();
    drain(1'b1);
  endtask

  task automatic push_word(int value, bit start);
    head_word_t w;
    w.value = 16'(value);
    w.start = start;
    word_q.insert(word_q.size(), w);
  endtask

  // -------------------------------------------------------------------------
  // Test sequence.
  // -------------------------------------------------------------------------
  initial begin
    board = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows at the reset settings (one class, 640 px, threshold 0.4).
    // Extreme offsets both ways drive the box fields to their limits, but at stride 8 none saturates.
    push_word(-32768, 1'b1); push_word(-32768, 1'b0); push_word(32767, 1'b0);
    push_word(32767, 1'b0);  push_word(0, 1'b0);      push_word(32767, 1'b0);
    push_word(32767, 1'b0);  push_word(32767, 1'b0);  push_word(-32768, 1'b0);
    push_word(-32768, 1'b0); push_word(-32768, 1'b0); push_word(-32768, 1'b0);
    // Last table bin.
    push_word(0, 1'b0);      push_word(0, 1'b0);      push_word(0, 1'b0);
    push_word(0, 1'b0);      push_word(32767, 1'b0);  push_word(4095, 1'b0);
    // A row cut short by a new frame start.
    push_word(256, 1'b0);    push_word(-256, 1'b0);   push_word(512, 1'b0);
    // A logit just on the upper side of the threshold's bin edge.
    push_word(128, 1'b1);    push_word(-128, 1'b0);   push_word(384, 1'b0);
    push_word(-384, 1'b0);   push_word(-1, 1'b0);     push_word(-104, 1'b0);
    push_word(-4096, 1'b0);  push_word(-96, 1'b0);    push_word(-4097, 1'b0);
    send_words();
    drain(1'b1);

    // Threshold zero: every logit whose table entry is nonzero passes; three classes.
    run_phase(3, 640, 0, 150, 6, 1'b1);
    // Widest row and the largest image that is a multiple of 32, with no idling on either side.
    calm = 1'b1;
    run_phase(255, 2016, 0, 260, 2, 1'b0);
    calm = 1'b0;
    // Rows with no classes, image not a multiple of 32.
    run_phase(0, 100, 0, 100, 8, 1'b1);
    // Tiny image, one long frame: the anchor counters wrap past the last cell.
    run_phase(1, 32, 26214, 250, 0, 1'b0);
    // Image smaller than the coarse strides; top threshold emits nothing.
    run_phase(2, 8, 65535, 60, 0, 1'b1);

    // Random settings, with one pause mid-phase until every detection is in.
    set_regs($urandom_range(8, 1),
             ($urandom_range(3) == 0) ? $urandom_range(2047, 32) : $urandom_range(4, 1) * 32,
             $urandom_range(65535));
    make_words(100, 30, 1'b1);
    send_words();
    drain(1'b0);
    make_words(100, 30, 1'b1);
    send_words();
    drain(1'b1);

    // Largest image the field holds, midpoint threshold.
    run_phase(4, 2047, 32768, 200, 10, 1'b1);
    // Back to the reset values.
    run_phase(1, 640, 26214, 150, 12, 1'b1);

    board.flag_leftover();
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
design/afbd_pkg.sv
design/afbd_in_if.sv
design/afbd_out_if.sv
design/afbd_front.sv
design/afbd_queue.sv
design/afbd_back.sv
design/anchor_free_box_decode.sv
tb/tb_anchor_free_box_decode.sv
